[rtl/assert_macros.svh]
// Assertion macros for the hill cipher core.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset; expects clk and rst_n in scope.
`define HC2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, also during reset; expects clk in scope.
`define HC2_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hc2_pkg.sv]
// Package for the 2x2 mod-26 hill cipher core: item types, codes, tables.
// No dependencies; used by the channel interface and the top level.
`default_nettype none

package hc2_pkg;

    localparam int LETTERS    = 26;
    localparam int LETTER_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C1 = 2'd3;

    // Directions
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
    } pair_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first_out;
        logic [LETTER_W-1:0] second_out;
        logic                key_not_invertible;
    } result_t;

    // Inverse of each residue mod 26; zero marks "no inverse".
    localparam logic [LETTER_W-1:0] INV_MOD26 [LETTERS] = '{
        5'd0,  5'd1,  5'd0,  5'd9,  5'd0,  5'd21, 5'd0,  5'd15, 5'd0,
        5'd3,  5'd0,  5'd19, 5'd0,  5'd0,  5'd0,  5'd7,  5'd0,  5'd23,
        5'd0,  5'd11, 5'd0,  5'd5,  5'd0,  5'd17, 5'd0,  5'd25
    };

    // Fold a 5-bit value 0..31 into 0..25.
    function automatic logic [LETTER_W-1:0] fold26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v >= 5'd26) ? (v - 5'd26) : v;
        return r;
    endfunction

    // Additive inverse mod 26 of a value already in 0..25.
    function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v == 5'd0) ? 5'd0 : (5'd26 - v);
        return r;
    endfunction

    // v mod 26 for v below 4096: quotient by reciprocal 2520/2^16 (floor or
    // floor-1), then one corrective subtract.
    function automatic logic [LETTER_W-1:0] mod26(input logic [11:0] v);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [12:0] qx;
        logic [11:0] r;
        prod = {12'd0, v} * 24'd2520;
        q    = prod[23:16];
        qx   = {5'd0, q} * 13'd26;
        r    = v - qx[11:0];
        if (r >= 12'd26)
            r = r - 12'd26;
        return r[LETTER_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/hc2_chan_if.sv]
// Valid/ready channel carrying one item of a chosen payload type.
// Payload types come from hc2_pkg.
`default_nettype none

interface hc2_chan_if #(
    parameter type payload_t = hc2_pkg::pair_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/hill_cipher_2x2_mod26_core.sv]
// Hill cipher core, 2x2 key, modulo 26: seven-stage pipeline.
// Depends on hc2_pkg, hc2_chan_if and assert_macros.svh.
// ---------------------------------------------------------------------------
// Usage
//   pair   : sink channel; one item = mode, first_letter, second_letter.
//            mode 0 encrypts with the key, mode 1 decrypts with its inverse.
//   result : source channel; one item = first_out, second_out,
//            key_not_invertible (decrypt with a singular key gives zeros).
//   cfg_*  : write port for the four key entries (index 0..3, row-major);
//            write only while no item is in flight.
// Path: an accepted pair is registered in stage 0 and moves on through stages
//   1 to 6; the stage 6 register drives result.
// Throughput: one item per cycle while result is not stalled; every stage
//   is a register with a valid bit, so seven stages hold seven items at once.
// Stall: each stage holds while its successor is full and stalled; the load
//   enables are formed combinationally back through all stages in the same
//   cycle, so bubbles are squeezed out and a new item is taken whenever the
//   first stage is free, even with a result waiting.
// Reset: valid bits clear, the key returns to the identity matrix.
// The inverse key is rebuilt per item from the key captured with it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hill_cipher_2x2_mod26_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hc2_chan_if.sink                            pair,
    hc2_chan_if.source                          result,
    input  wire logic                           cfg_we,
    input  wire logic [hc2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hc2_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 7;
    localparam int W    = hc2_pkg::LETTER_W;

    // ---------------- key registers ----------------
    logic [W-1:0] key_row0_col0_reg, key_row0_col1_reg;
    logic [W-1:0] key_row1_col0_reg, key_row1_col1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_row0_col0_reg <= 5'd1;
            key_row0_col1_reg <= 5'd0;
            key_row1_col0_reg <= 5'd0;
            key_row1_col1_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hc2_pkg::REG_KEY_R0C0: key_row0_col0_reg <= cfg_data;
                hc2_pkg::REG_KEY_R0C1: key_row0_col1_reg <= cfg_data;
                hc2_pkg::REG_KEY_R1C0: key_row1_col0_reg <= cfg_data;
                hc2_pkg::REG_KEY_R1C1: key_row1_col1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // go[k]: stage k may load this cycle (empty, or its item moves on).
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   go;

    always_comb
    begin
        go[NSTG] = result.ready;
        for (int k = NSTG - 1; k >= 0; k--)
            go[k] = !vld_reg[k] || go[k+1];
    end

    assign pair.ready = go[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (go[0])
                vld_reg[0] <= pair.valid;
            for (int k = 1; k < NSTG; k++)
                if (go[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- stage 0: fold inputs and key into 0..25 ----------------
    logic         mode0_reg;
    logic [W-1:0] x0_reg, y0_reg, a0_reg, b0_reg, c0_reg, d0_reg;

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            mode0_reg <= pair.payload.mode;
            x0_reg    <= hc2_pkg::fold26(pair.payload.first_letter);
            y0_reg    <= hc2_pkg::fold26(pair.payload.second_letter);
            a0_reg    <= hc2_pkg::fold26(key_row0_col0_reg);
            b0_reg    <= hc2_pkg::fold26(key_row0_col1_reg);
            c0_reg    <= hc2_pkg::fold26(key_row1_col0_reg);
            d0_reg    <= hc2_pkg::fold26(key_row1_col1_reg);
        end
    end

    // ---------------- stage 1: determinant and encrypt products ----------------
    logic         mode1_reg;
    logic [W-1:0] x1_reg, y1_reg, a1_reg, nb1_reg, nc1_reg, d1_reg;
    logic [9:0]   ad1_reg, bc1_reg, ax1_reg, by1_reg, cx1_reg, dy1_reg;

    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            mode1_reg <= mode0_reg;
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            a1_reg    <= a0_reg;
            nb1_reg   <= hc2_pkg::neg26(b0_reg);
            nc1_reg   <= hc2_pkg::neg26(c0_reg);
            d1_reg    <= d0_reg;
            ad1_reg   <= {5'd0, a0_reg} * {5'd0, d0_reg};
            bc1_reg   <= {5'd0, b0_reg} * {5'd0, c0_reg};
            ax1_reg   <= {5'd0, a0_reg} * {5'd0, x0_reg};
            by1_reg   <= {5'd0, b0_reg} * {5'd0, y0_reg};
            cx1_reg   <= {5'd0, c0_reg} * {5'd0, x0_reg};
            dy1_reg   <= {5'd0, d0_reg} * {5'd0, y0_reg};
        end
    end

    // ---------------- stage 2: reductions mod 26 ----------------
    // 676 = 26*26 keeps ad - bc non-negative.
    logic         mode2_reg;
    logic [W-1:0] x2_reg, y2_reg, a2_reg, nb2_reg, nc2_reg, d2_reg;
    logic [W-1:0] det2_reg, e0_2_reg, e1_2_reg;

    always_ff @(posedge clk)
    begin
        if (go[2])
        begin
            mode2_reg <= mode1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            a2_reg    <= a1_reg;
            nb2_reg   <= nb1_reg;
            nc2_reg   <= nc1_reg;
            d2_reg    <= d1_reg;
            det2_reg  <= hc2_pkg::mod26({2'd0, ad1_reg} + 12'd676 - {2'd0, bc1_reg});
            e0_2_reg  <= hc2_pkg::mod26({2'd0, ax1_reg} + {2'd0, by1_reg});
            e1_2_reg  <= hc2_pkg::mod26({2'd0, cx1_reg} + {2'd0, dy1_reg});
        end
    end

    // ---------------- stage 3: inverse determinant, scaled adjugate ----------------
    logic [W-1:0] dinv;
    assign dinv = hc2_pkg::INV_MOD26[det2_reg];

    logic         mode3_reg, ninv3_reg;
    logic [W-1:0] x3_reg, y3_reg, e0_3_reg, e1_3_reg;
    logic [9:0]   p00_3_reg, p01_3_reg, p10_3_reg, p11_3_reg;

    always_ff @(posedge clk)
    begin
        if (go[3])
        begin
            mode3_reg <= mode2_reg;
            ninv3_reg <= (dinv == 5'd0);
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            e0_3_reg  <= e0_2_reg;
            e1_3_reg  <= e1_2_reg;
            p00_3_reg <= {5'd0, d2_reg}  * {5'd0, dinv};
            p01_3_reg <= {5'd0, nb2_reg} * {5'd0, dinv};
            p10_3_reg <= {5'd0, nc2_reg} * {5'd0, dinv};
            p11_3_reg <= {5'd0, a2_reg}  * {5'd0, dinv};
        end
    end

    // ---------------- stage 4: inverse key entries ----------------
    logic         mode4_reg, ninv4_reg;
    logic [W-1:0] x4_reg, y4_reg, e0_4_reg, e1_4_reg;
    logic [W-1:0] i00_4_reg, i01_4_reg, i10_4_reg, i11_4_reg;

    always_ff @(posedge clk)
    begin
        if (go[4])
        begin
            mode4_reg <= mode3_reg;
            ninv4_reg <= ninv3_reg;
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
            e0_4_reg  <= e0_3_reg;
            e1_4_reg  <= e1_3_reg;
            i00_4_reg <= hc2_pkg::mod26({2'd0, p00_3_reg});
            i01_4_reg <= hc2_pkg::mod26({2'd0, p01_3_reg});
            i10_4_reg <= hc2_pkg::mod26({2'd0, p10_3_reg});
            i11_4_reg <= hc2_pkg::mod26({2'd0, p11_3_reg});
        end
    end

    // ---------------- stage 5: decrypt products ----------------
    logic         mode5_reg, ninv5_reg;
    logic [W-1:0] e0_5_reg, e1_5_reg;
    logic [9:0]   q00_5_reg, q01_5_reg, q10_5_reg, q11_5_reg;

    always_ff @(posedge clk)
    begin
        if (go[5])
        begin
            mode5_reg <= mode4_reg;
            ninv5_reg <= ninv4_reg;
            e0_5_reg  <= e0_4_reg;
            e1_5_reg  <= e1_4_reg;
            q00_5_reg <= {5'd0, i00_4_reg} * {5'd0, x4_reg};
            q01_5_reg <= {5'd0, i01_4_reg} * {5'd0, y4_reg};
            q10_5_reg <= {5'd0, i10_4_reg} * {5'd0, x4_reg};
            q11_5_reg <= {5'd0, i11_4_reg} * {5'd0, y4_reg};
        end
    end

    // ---------------- stage 6: output register ----------------
    hc2_pkg::result_t res_next, res_reg;
    logic [W-1:0]     dec0, dec1;

    always_comb
    begin
        dec0     = hc2_pkg::mod26({2'd0, q00_5_reg} + {2'd0, q01_5_reg});
        dec1     = hc2_pkg::mod26({2'd0, q10_5_reg} + {2'd0, q11_5_reg});
        res_next = '0;
        if (mode5_reg == hc2_pkg::MODE_ENCRYPT)
        begin
            res_next.first_out  = e0_5_reg;
            res_next.second_out = e1_5_reg;
        end
        else if (ninv5_reg)
            res_next.key_not_invertible = 1'b1;
        else
        begin
            res_next.first_out  = dec0;
            res_next.second_out = dec1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[6])
            res_reg <= res_next;
    end

    assign result.valid   = vld_reg[NSTG-1];
    assign result.payload = res_reg;

    // ---------------- assertions ----------------
    `HC2_ASSERT(a_flag_zeroes,
        result.valid && result.payload.key_not_invertible
            |-> result.payload.first_out == 5'd0 && result.payload.second_out == 5'd0,
        "flagged result carries nonzero letters")
    `HC2_ASSERT(a_out_range,
        result.valid
            |-> result.payload.first_out < 5'd26 && result.payload.second_out < 5'd26,
        "result letter outside 0..25")
    `HC2_ASSERT_ALWAYS(a_free_head_ready, !vld_reg[0] |-> pair.ready,
        "empty first stage refuses an item")
    `HC2_ASSERT(a_stall_keeps,
        vld_reg[NSTG-1] && !result.ready |=> vld_reg[NSTG-1] && $stable(res_reg),
        "stalled result lost or changed")

endmodule

`default_nettype wire
